[rtl/fscw_pkg.sv]
// Shared types, character codes and helpers for the format string console writer.
`default_nettype none

package fscw_pkg;

  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitIdxW = 4;
  localparam int unsigned BcdW      = NumDigits * 4;
  localparam int unsigned ArgW      = 32;
  localparam int unsigned ConvSteps = 8;
  localparam int unsigned ConvCntW  = 3;

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChBs      = 8'h08;
  localparam logic [7:0] ChNl      = 8'h0A;
  localparam logic [7:0] ChPct     = 8'h25;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChLowerC  = 8'h63;
  localparam logic [7:0] ChLowerD  = 8'h64;
  localparam logic [7:0] ChLowerX  = 8'h78;
  localparam logic [7:0] GlyphErase = 8'h00;
  localparam logic [7:0] CursorMax = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT,
    ST_CHAR
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ARM,
    OP_CHAR_FMT,
    OP_CHAR_ARG,
    OP_CHAR_PCT,
    OP_DEC,
    OP_HEX
  } op_t;

  typedef enum logic [1:0] {
    CH_FMT,
    CH_ARG,
    CH_PCT
  } ch_src_t;

  typedef struct packed {
    logic    ld_char;
    ch_src_t ch_src;
    logic    ld_dec;
    logic    ld_hex;
    logic    conv_step;
    logic    set_idx;
    logic    emit_digit;
    logic    char_go;
  } cmd_t;

  typedef struct packed {
    logic char_emits;
    logic out_free;
    logic idx_zero;
  } sts_t;

  function automatic logic [7:0] digit_glyph(input logic [3:0] nib);
    logic [7:0] g;
    if (nib < 4'd10) begin
      g = ChZero + {4'd0, nib};
    end else begin
      g = ChUpperA + {4'd0, nib} - 8'd10;
    end
    return g;
  endfunction

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == CursorMax) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

[rtl/fscw_ctrl.sv]
// Controller: format decode, specifier flag and sequencing of conversion and writes.
`default_nettype none

module fscw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       fmt_byte,
  input  wire fscw_pkg::sts_t   sts,
  output fscw_pkg::cmd_t        cmd
);

  fscw_pkg::state_t state_r, state_nxt;
  logic             spec_r, spec_nxt;
  logic [fscw_pkg::ConvCntW-1:0] cnt_r, cnt_nxt;
  fscw_pkg::op_t    op;

  always_comb begin
    op = fscw_pkg::OP_NONE;
    if (fmt_byte == fscw_pkg::ChNul) begin
      op = fscw_pkg::OP_NONE;
    end else if (!spec_r) begin
      op = (fmt_byte == fscw_pkg::ChPct) ? fscw_pkg::OP_ARM : fscw_pkg::OP_CHAR_FMT;
    end else begin
      case (fmt_byte)
        fscw_pkg::ChLowerD: op = fscw_pkg::OP_DEC;
        fscw_pkg::ChLowerX: op = fscw_pkg::OP_HEX;
        fscw_pkg::ChLowerC: op = fscw_pkg::OP_CHAR_ARG;
        fscw_pkg::ChPct:    op = fscw_pkg::OP_CHAR_PCT;
        default:            op = fscw_pkg::OP_NONE;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    spec_nxt  = spec_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      fscw_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          spec_nxt = (op == fscw_pkg::OP_ARM);
          cnt_nxt  = '0;
          case (op)
            fscw_pkg::OP_CHAR_FMT,
            fscw_pkg::OP_CHAR_ARG,
            fscw_pkg::OP_CHAR_PCT: state_nxt = fscw_pkg::ST_CHAR;
            fscw_pkg::OP_DEC:      state_nxt = fscw_pkg::ST_CONV;
            fscw_pkg::OP_HEX:      state_nxt = fscw_pkg::ST_SCAN;
            default:               state_nxt = fscw_pkg::ST_IDLE;
          endcase
        end
      end
      fscw_pkg::ST_CONV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == fscw_pkg::ConvCntW'(fscw_pkg::ConvSteps - 1)) begin
          state_nxt = fscw_pkg::ST_SCAN;
        end
      end
      fscw_pkg::ST_SCAN: state_nxt = fscw_pkg::ST_EMIT;
      fscw_pkg::ST_EMIT: begin
        if (sts.out_free && sts.idx_zero) begin
          state_nxt = fscw_pkg::ST_IDLE;
        end
      end
      fscw_pkg::ST_CHAR: begin
        if (sts.out_free || !sts.char_emits) begin
          state_nxt = fscw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fscw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.ch_src = fscw_pkg::CH_FMT;
    in_tready = 1'b0;
    case (state_r)
      fscw_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (op)
            fscw_pkg::OP_CHAR_FMT: cmd.ld_char = 1'b1;
            fscw_pkg::OP_CHAR_ARG: begin
              cmd.ld_char = 1'b1;
              cmd.ch_src  = fscw_pkg::CH_ARG;
            end
            fscw_pkg::OP_CHAR_PCT: begin
              cmd.ld_char = 1'b1;
              cmd.ch_src  = fscw_pkg::CH_PCT;
            end
            fscw_pkg::OP_DEC: cmd.ld_dec = 1'b1;
            fscw_pkg::OP_HEX: cmd.ld_hex = 1'b1;
            default: ;
          endcase
        end
      end
      fscw_pkg::ST_CONV: cmd.conv_step = 1'b1;
      fscw_pkg::ST_SCAN: cmd.set_idx   = 1'b1;
      fscw_pkg::ST_EMIT: cmd.emit_digit = sts.out_free;
      fscw_pkg::ST_CHAR: cmd.char_go = sts.out_free || !sts.char_emits;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fscw_pkg::ST_IDLE;
      spec_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      spec_r  <= spec_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/fscw_dpath.sv]
// Datapath: binary to BCD conversion, digit buffer, cursor and output register.
`default_nettype none

module fscw_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [7:0]                fmt_byte,
  input  wire logic [fscw_pkg::ArgW-1:0] arg_value,
  input  wire fscw_pkg::cmd_t            cmd,
  output fscw_pkg::sts_t                 sts,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [7:0]                     out_column,
  output logic [7:0]                     out_row,
  output logic [7:0]                     out_glyph,
  output logic                           out_last
);

  logic [fscw_pkg::BcdW-1:0]      bcd_r, bcd_nxt, conv_bcd;
  logic [fscw_pkg::ArgW-1:0]      src_r, src_nxt, conv_src;
  logic [fscw_pkg::DigitIdxW-1:0] idx_r, idx_nxt, start_idx;
  logic [7:0]                     ch_r, ch_nxt;
  logic [7:0]                     col_r, col_nxt, row_r, row_nxt;
  logic                           out_vld_r, out_vld_nxt;
  logic [7:0]                     ocol_r, ocol_nxt, orow_r, orow_nxt, oglyph_r, oglyph_nxt;
  logic                           olast_r, olast_nxt;
  logic                           ch_is_nl, ch_is_bs, col_zero;

  always_comb begin
    conv_bcd = bcd_r;
    conv_src = src_r;
    for (int k = 0; k < 4; k++) begin
      for (int d = 0; d < fscw_pkg::NumDigits; d++) begin
        if (conv_bcd[d*4 +: 4] >= 4'd5) begin
          conv_bcd[d*4 +: 4] = conv_bcd[d*4 +: 4] + 4'd3;
        end
      end
      conv_bcd = {conv_bcd[fscw_pkg::BcdW-2:0], conv_src[fscw_pkg::ArgW-1]};
      conv_src = {conv_src[fscw_pkg::ArgW-2:0], 1'b0};
    end
  end

  always_comb begin
    start_idx = '0;
    for (int d = 1; d < fscw_pkg::NumDigits; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        start_idx = fscw_pkg::DigitIdxW'(d);
      end
    end
  end

  assign ch_is_nl = (ch_r == fscw_pkg::ChNl);
  assign ch_is_bs = (ch_r == fscw_pkg::ChBs);
  assign col_zero = (col_r == 8'd0);

  assign sts.char_emits = !ch_is_nl && !(ch_is_bs && col_zero);
  assign sts.out_free   = !out_vld_r || out_tready;
  assign sts.idx_zero   = (idx_r == '0);

  always_comb begin
    bcd_nxt     = bcd_r;
    src_nxt     = src_r;
    idx_nxt     = idx_r;
    ch_nxt      = ch_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    out_vld_nxt = out_vld_r && !out_tready;
    ocol_nxt    = ocol_r;
    orow_nxt    = orow_r;
    oglyph_nxt  = oglyph_r;
    olast_nxt   = olast_r;

    if (cmd.ld_char) begin
      case (cmd.ch_src)
        fscw_pkg::CH_ARG: ch_nxt = arg_value[7:0];
        fscw_pkg::CH_PCT: ch_nxt = fscw_pkg::ChPct;
        default:          ch_nxt = fmt_byte;
      endcase
    end
    if (cmd.ld_dec) begin
      bcd_nxt = '0;
      src_nxt = arg_value;
    end
    if (cmd.ld_hex) begin
      bcd_nxt = {{(fscw_pkg::BcdW - fscw_pkg::ArgW){1'b0}}, arg_value};
    end
    if (cmd.conv_step) begin
      bcd_nxt = conv_bcd;
      src_nxt = conv_src;
    end
    if (cmd.set_idx) begin
      idx_nxt = start_idx;
    end
    if (cmd.emit_digit) begin
      out_vld_nxt = 1'b1;
      ocol_nxt    = col_r;
      orow_nxt    = row_r;
      oglyph_nxt  = fscw_pkg::digit_glyph(bcd_r[idx_r*4 +: 4]);
      olast_nxt   = (idx_r == '0);
      col_nxt     = fscw_pkg::sat_inc(col_r);
      idx_nxt     = idx_r - 1'b1;
    end
    if (cmd.char_go) begin
      if (ch_is_nl) begin
        row_nxt = fscw_pkg::sat_inc(row_r);
        col_nxt = 8'd0;
      end else if (ch_is_bs) begin
        if (!col_zero) begin
          out_vld_nxt = 1'b1;
          ocol_nxt    = col_r - 8'd1;
          orow_nxt    = row_r;
          oglyph_nxt  = fscw_pkg::GlyphErase;
          olast_nxt   = 1'b1;
          col_nxt     = col_r - 8'd1;
        end
      end else begin
        out_vld_nxt = 1'b1;
        ocol_nxt    = col_r;
        orow_nxt    = row_r;
        oglyph_nxt  = ch_r;
        olast_nxt   = 1'b1;
        col_nxt     = fscw_pkg::sat_inc(col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= 8'd0;
      row_r     <= 8'd0;
      out_vld_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r    <= bcd_nxt;
    src_r    <= src_nxt;
    idx_r    <= idx_nxt;
    ch_r     <= ch_nxt;
    ocol_r   <= ocol_nxt;
    orow_r   <= orow_nxt;
    oglyph_r <= oglyph_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_column = ocol_r;
  assign out_row    = orow_r;
  assign out_glyph  = oglyph_r;
  assign out_last   = olast_r;

endmodule

`default_nettype wire

[rtl/format_string_console_writer.sv]
// Top level of the format string console writer: controller plus datapath.
//
// Input stream: one request per format byte. in_tdata carries fmt_byte in
// [7:0] and arg_value in [39:8]. A percent sign arms a specifier; the next
// byte selects d (unsigned decimal), x (upper-case hex), c (low argument
// byte) or a literal percent sign. Other specifiers and a zero byte write
// nothing.
// Output stream: one request per character write, with column, row and
// glyph in out_tdata and out_tlast on the final write of a request.
// Steps: a plain character, %c or %% passes the idle and character states
// and then the output register. %x passes a scan state and then writes n
// digits from the highest nonzero one (n up to 8); %d first runs the binary to
// BCD converter, four bits a cycle, then scans and writes n digits (n up to
// 10). Newline and backspace at column zero write nothing; ignored bytes and a
// percent sign that arms a specifier leave the block idle.
// The next request is taken while the last write still waits in the output
// register; a stalled receiver holds the block once a new write is due.
// Reset clears the cursor to column 0, row 0, drops any pending write and
// disarms the specifier.
`default_nettype none

module format_string_console_writer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // fmt_byte [7:0], arg_value [39:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // column [7:0], row [15:8], glyph [23:16]
  output logic             out_tlast
);

  fscw_pkg::cmd_t cmd;
  fscw_pkg::sts_t sts;
  logic [7:0]     out_column, out_row, out_glyph;

  fscw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .fmt_byte  (in_tdata[7:0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  fscw_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .fmt_byte   (in_tdata[7:0]),
    .arg_value  (in_tdata[39:8]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_column (out_column),
    .out_row    (out_row),
    .out_glyph  (out_glyph),
    .out_last   (out_tlast)
  );

  assign out_tdata = {out_glyph, out_row, out_column};

endmodule

`default_nettype wire

[rtl/fscw_checker.sv]
// Port-level checker for the format string console writer, bound to the top level.
`default_nettype none

module fscw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output request changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear output and return to idle");

  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("pending write while idle is not the final one");

  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |-> !in_tready)
    else $error("input taken while a request is still writing");

endmodule

bind format_string_console_writer fscw_checker u_fscw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
